// ===== design/dtadd_pkg.sv =====
// ----------------------------------------------------------------------------
// dtadd_pkg
// Shared types and constants for the date and time offset adder.
// ----------------------------------------------------------------------------
package dtadd_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned YearIW  = 15;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned SecW    = 6;
  localparam int unsigned OffW    = 31;
  localparam int unsigned TodW    = 18;
  localparam int unsigned ProdW   = 30;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 40;

  localparam logic [OffW-1:0] SecsPerDay  = 31'd86400;
  localparam logic [OffW-1:0] SecsPerYear = 31'd31536000;
  localparam logic [OffW-1:0] SecsPerLeap = 31'd31622400;
  localparam logic [TodW-1:0] SecsPerHour = 18'd3600;
  localparam logic [TodW-1:0] SecsPerMin  = 18'd60;
  localparam logic [MonthW:0] LastMonth   = 5'd12;

  // reciprocal of 25 scaled by 2^20, exact for years below 2^15
  localparam logic [15:0] Recip25  = 16'd41944;
  localparam int unsigned RecipSh  = 20;

  typedef struct packed {
    logic load;
    logic fix_mod;
    logic day_t;
    logic year;
    logic tod_add;
    logic day_tod;
    logic hour;
    logic minute;
    logic out_load;
  } dtadd_cmd_t;

  typedef struct packed {
    logic at_jan1;
    logic t_ge_day;
    logic t_ge_year;
    logic tod_ge_day;
    logic tod_ge_hour;
    logic tod_ge_min;
  } dtadd_stat_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== design/dtadd_dp.sv =====
// ----------------------------------------------------------------------------
// dtadd_dp
// Datapath: date registers, remaining offset, time of day, leap tracking and
// the result registers, all stepped by commands from the controller.
// ----------------------------------------------------------------------------
module dtadd_dp
  import dtadd_pkg::*;
(
  input  logic              clk_i,
  input  dtadd_cmd_t        cmd_i,
  output dtadd_stat_t       stat_o,
  input  logic [YearW-1:0]  start_year_i,
  input  logic [MonthW-1:0] start_month_i,
  input  logic [DayW-1:0]   start_day_i,
  input  logic [HourW-1:0]  start_hour_i,
  input  logic [MinW-1:0]   start_minute_i,
  input  logic [SecW-1:0]   start_second_i,
  input  logic [OffW-1:0]   offset_seconds_i,
  output logic [YearW-1:0]  end_year_o,
  output logic [MonthW-1:0] end_month_o,
  output logic [DayW-1:0]   end_day_o,
  output logic [HourW-1:0]  end_hour_o,
  output logic [MinW-1:0]   end_minute_o,
  output logic [SecW-1:0]   end_second_o
);

  logic [YearIW-1:0] y_q, y_d;
  logic [MonthW-1:0] m_q, m_d;
  logic [DayW-1:0]   d_q, d_d;
  logic [OffW-1:0]   t_q, t_d;
  logic [TodW-1:0]   tod_q, tod_d;
  logic [4:0]        r25_q, r25_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [HourW-1:0]  hr_q, hr_d;
  logic [MinW-1:0]   mn_q, mn_d;

  logic [YearW-1:0]  oy_q;
  logic [MonthW-1:0] om_q;
  logic [DayW-1:0]   od_q;
  logic [HourW-1:0]  oh_q;
  logic [MinW-1:0]   omn_q;
  logic [SecW-1:0]   os_q;

  logic              leap;
  logic [OffW-1:0]   year_secs;
  logic [DayW:0]     d_inc;
  logic [MonthW:0]   m_inc;
  logic [DayW-1:0]   nd_day;
  logic [MonthW:0]   nd_month;
  logic              nd_carry;
  logic [YearIW-1:0] y_inc;
  logic [4:0]        r25_inc;
  logic [9:0]        quo;
  logic [YearIW-1:0] quo25;
  logic [YearIW-1:0] rem25;
  logic [TodW-1:0]   base;

  // leap: multiple of 4, and of 16 when a multiple of 25
  assign leap      = (y_q[1:0] == 2'd0) && ((r25_q != 5'd0) || (y_q[3:0] == 4'd0));
  assign year_secs = leap ? SecsPerLeap : SecsPerYear;

  assign y_inc   = y_q + YearIW'(1);
  assign r25_inc = (r25_q == 5'd24) ? 5'd0 : r25_q + 5'd1;

  // next calendar day
  always_comb begin
    d_inc = {1'b0, d_q} + 6'd1;
    m_inc = {1'b0, m_q} + 5'd1;
    if (d_inc > {1'b0, month_len(m_q, leap)}) begin
      nd_day   = 5'd1;
      nd_month = m_inc;
    end else begin
      nd_day   = d_inc[DayW-1:0];
      nd_month = {1'b0, m_q};
    end
    nd_carry = nd_month > LastMonth;
    if (nd_carry) begin
      nd_month = 5'd1;
    end
  end

  assign quo   = prod_q[ProdW-1:RecipSh];
  assign quo25 = YearIW'({quo, 4'b0}) + YearIW'({quo, 3'b0}) + YearIW'(quo);
  assign rem25 = y_q - quo25;

  assign base = TodW'(start_hour_i) * 18'd3600 + TodW'(start_minute_i) * 18'd60
              + TodW'(start_second_i);

  always_comb begin
    y_d    = y_q;
    m_d    = m_q;
    d_d    = d_q;
    t_d    = t_q;
    tod_d  = tod_q;
    r25_d  = r25_q;
    prod_d = prod_q;
    hr_d   = hr_q;
    mn_d   = mn_q;
    if (cmd_i.load) begin
      y_d    = YearIW'(start_year_i);
      m_d    = start_month_i;
      d_d    = start_day_i;
      t_d    = offset_seconds_i;
      tod_d  = base;
      prod_d = ProdW'(start_year_i) * ProdW'(Recip25);
      hr_d   = '0;
      mn_d   = '0;
    end
    if (cmd_i.fix_mod) begin
      r25_d = rem25[4:0];
    end
    if (cmd_i.day_t || cmd_i.day_tod) begin
      d_d = nd_day;
      m_d = nd_month[MonthW-1:0];
      if (nd_carry) begin
        y_d   = y_inc;
        r25_d = r25_inc;
      end
      if (cmd_i.day_t) begin
        t_d = t_q - SecsPerDay;
      end else begin
        tod_d = tod_q - TodW'(SecsPerDay);
      end
    end
    if (cmd_i.year) begin
      t_d   = t_q - year_secs;
      y_d   = y_inc;
      r25_d = r25_inc;
    end
    if (cmd_i.tod_add) begin
      tod_d = tod_q + t_q[TodW-1:0];
    end
    if (cmd_i.hour) begin
      tod_d = tod_q - SecsPerHour;
      hr_d  = hr_q + HourW'(1);
    end
    if (cmd_i.minute) begin
      tod_d = tod_q - SecsPerMin;
      mn_d  = mn_q + MinW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    y_q    <= y_d;
    m_q    <= m_d;
    d_q    <= d_d;
    t_q    <= t_d;
    tod_q  <= tod_d;
    r25_q  <= r25_d;
    prod_q <= prod_d;
    hr_q   <= hr_d;
    mn_q   <= mn_d;
    if (cmd_i.out_load) begin
      oy_q  <= y_q[YearW-1:0];
      om_q  <= m_q;
      od_q  <= d_q;
      oh_q  <= hr_q;
      omn_q <= mn_q;
      os_q  <= tod_q[SecW-1:0];
    end
  end

  assign stat_o.at_jan1     = (m_q == 4'd1) && (d_q == 5'd1);
  assign stat_o.t_ge_day    = t_q >= SecsPerDay;
  assign stat_o.t_ge_year   = t_q >= year_secs;
  assign stat_o.tod_ge_day  = tod_q >= TodW'(SecsPerDay);
  assign stat_o.tod_ge_hour = tod_q >= SecsPerHour;
  assign stat_o.tod_ge_min  = tod_q >= SecsPerMin;

  assign end_year_o   = oy_q;
  assign end_month_o  = om_q;
  assign end_day_o    = od_q;
  assign end_hour_o   = oh_q;
  assign end_minute_o = omn_q;
  assign end_second_o = os_q;

endmodule

// ===== design/dtadd_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtadd_ctrl
// Controller: sequences the day, year and time-of-day steps and owns the
// stream handshakes.
// ----------------------------------------------------------------------------
module dtadd_ctrl
  import dtadd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  input  dtadd_stat_t stat_i,
  output dtadd_cmd_t  cmd_o
);

  typedef enum logic [9:0] {
    StIdle   = 10'b0000000001,
    StMod    = 10'b0000000010,
    StFwd    = 10'b0000000100,
    StYear   = 10'b0000001000,
    StDays   = 10'b0000010000,
    StTodAdd = 10'b0000100000,
    StWrap   = 10'b0001000000,
    StHour   = 10'b0010000000,
    StMin    = 10'b0100000000,
    StFin    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   mvalid_q, mvalid_d;

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    s_ready_o = 1'b0;
    mvalid_d = mvalid_q && !m_ready_i;
    case (state_q)
      StIdle: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StMod;
        end
      end
      StMod: begin
        cmd_o.fix_mod = 1'b1;
        state_d       = StFwd;
      end
      StFwd: begin
        if (!stat_i.at_jan1 && stat_i.t_ge_day) begin
          cmd_o.day_t = 1'b1;
        end else begin
          state_d = StYear;
        end
      end
      StYear: begin
        if (stat_i.t_ge_year) begin
          cmd_o.year = 1'b1;
        end else begin
          state_d = StDays;
        end
      end
      StDays: begin
        if (stat_i.t_ge_day) begin
          cmd_o.day_t = 1'b1;
        end else begin
          state_d = StTodAdd;
        end
      end
      StTodAdd: begin
        cmd_o.tod_add = 1'b1;
        state_d       = StWrap;
      end
      StWrap: begin
        if (stat_i.tod_ge_day) begin
          cmd_o.day_tod = 1'b1;
        end else begin
          state_d = StHour;
        end
      end
      StHour: begin
        if (stat_i.tod_ge_hour) begin
          cmd_o.hour = 1'b1;
        end else begin
          state_d = StMin;
        end
      end
      StMin: begin
        if (stat_i.tod_ge_min) begin
          cmd_o.minute = 1'b1;
        end else begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (!mvalid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          mvalid_d       = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mvalid_q <= mvalid_d;
    end
  end

  assign m_valid_o = mvalid_q;

endmodule

// ===== design/datetime_add_seconds.sv =====
// ----------------------------------------------------------------------------
// datetime_add_seconds
// Adds an unsigned offset in seconds to a Gregorian date and time.
//
//   channel  dir  tdata                                       tuser  tlast
//   s_axis   in   72b: year, month, day, hour, min, sec, ofs  -      -
//   m_axis   out  40b: year, month, day, hour, min, sec       -      -
//
// one beat in, one beat out; each beat is worked off in steps: F and D single day
// steps (up to 365 each), Y whole years (up to 68), W day carries out of the
// time of day (up to 2), H hours (up to 23) and M minutes (up to 59), one
// step per cycle
// a new beat is taken while the previous result waits; a full output stalls
// reset clears the controller and the output valid; no clearing pass
// ----------------------------------------------------------------------------
module datetime_add_seconds
  import dtadd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // year[13:0] month[17:14] day[22:18] hour[27:23] minute[33:28]
  // second[39:34] offset_seconds[70:40] zero[71]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // year[13:0] month[17:14] day[22:18] hour[27:23] minute[33:28] second[39:34]
  output logic [OutDataW-1:0] m_axis_tdata
);

  dtadd_cmd_t  cmd;
  dtadd_stat_t stat;

  logic [YearW-1:0]  end_year;
  logic [MonthW-1:0] end_month;
  logic [DayW-1:0]   end_day;
  logic [HourW-1:0]  end_hour;
  logic [MinW-1:0]   end_minute;
  logic [SecW-1:0]   end_second;

  dtadd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  dtadd_dp u_dp (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .start_year_i     (s_axis_tdata[13:0]),
    .start_month_i    (s_axis_tdata[17:14]),
    .start_day_i      (s_axis_tdata[22:18]),
    .start_hour_i     (s_axis_tdata[27:23]),
    .start_minute_i   (s_axis_tdata[33:28]),
    .start_second_i   (s_axis_tdata[39:34]),
    .offset_seconds_i (s_axis_tdata[70:40]),
    .end_year_o       (end_year),
    .end_month_o      (end_month),
    .end_day_o        (end_day),
    .end_hour_o       (end_hour),
    .end_minute_o     (end_minute),
    .end_second_o     (end_second)
  );

  assign m_axis_tdata = {end_second, end_minute, end_hour, end_day, end_month, end_year};

endmodule

// ===== sim/datetime_add_seconds_test.sv =====
// ----------------------------------------------------------------------------
// datetime_add_seconds_test
// Self-checking bench for the date and time offset adder. Each beat sent in
// is run through a local calendar predictor and the expected moment is
// queued. Every beat taken on the master side is compared field by field with
// the oldest queued moment. The stimulus is a directed set of calendar corner
// cases followed by random beats, mostly valid dates with a mix of offsets and
// some raw out-of-range fields. Both sides idle at random, with one calm
// stretch, and the receiver holds off once for a long time.
// ----------------------------------------------------------------------------
module datetime_add_seconds_test;
  import dtadd_pkg::*;

  localparam int unsigned DaySecs    = 86400;
  localparam int unsigned RandBeats  = 600;
  localparam int unsigned HoldCycles = 3000;
  localparam int unsigned HoldAt     = 150;
  localparam int unsigned CalmFrom   = 300;
  localparam int unsigned CalmTo     = 420;
  localparam int unsigned TailCycles = 1000;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned PrintCap   = 50;

  typedef struct packed {
    logic [OffW-1:0]   ofs;
    logic [SecW-1:0]   sec;
    logic [MinW-1:0]   minute;
    logic [HourW-1:0]  hour;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } dt_beat_t;

  typedef struct packed {
    logic [SecW-1:0]   sec;
    logic [MinW-1:0]   minute;
    logic [HourW-1:0]  hour;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } dt_moment_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  dt_beat_t    start_beats[$];
  dt_moment_t  due_moments[$];
  dt_beat_t    cur_beat;
  dt_moment_t  got_moment, want_moment;
  int unsigned beats_sent = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned stall_cycles = 0;
  int unsigned directed_cnt = 0;
  int unsigned noisy_cnt = 0;
  logic        calm_in, calm_out;

  datetime_add_seconds DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic bit is_leap(input int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int unsigned days_in(input int unsigned y, input int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic void step_day(inout int unsigned y, inout int unsigned m,
                                   inout int unsigned d);
    d = d + 1;
    if (d > days_in(y, m)) begin
      d = 1;
      m = m + 1;
    end
    if (m > 12) begin
      m = 1;
      y = y + 1;
    end
  endfunction

  function automatic dt_moment_t advance_moment(input dt_beat_t b);
    int unsigned y, m, d, t, tod, span;
    dt_moment_t r;
    y = b.year;
    m = b.month;
    d = b.day;
    t = b.ofs;
    // single days up to the next new year
    while (!(m == 1 && d == 1) && t >= DaySecs) begin
      t = t - DaySecs;
      step_day(y, m, d);
    end
    span = (is_leap(y) ? 366 : 365) * DaySecs;
    while (t >= span) begin
      t = t - span;
      y = y + 1;
      span = (is_leap(y) ? 366 : 365) * DaySecs;
    end
    while (t >= DaySecs) begin
      t = t - DaySecs;
      step_day(y, m, d);
    end
    tod = b.hour * 3600 + b.minute * 60 + b.sec + t;
    while (tod >= DaySecs) begin
      tod = tod - DaySecs;
      step_day(y, m, d);
    end
    r.year   = y[YearW-1:0];
    r.month  = m[MonthW-1:0];
    r.day    = d[DayW-1:0];
    r.hour   = 5'((tod / 3600));
    r.minute = 6'(((tod / 60) % 60));
    r.sec    = 6'((tod % 60));
    return r;
  endfunction

  function automatic dt_beat_t mk_beat(input int unsigned y, input int unsigned mo,
                                       input int unsigned d, input int unsigned h,
                                       input int unsigned mi, input int unsigned s,
                                       input int unsigned ofs);
    dt_beat_t b;
    b.year   = y[YearW-1:0];
    b.month  = mo[MonthW-1:0];
    b.day    = d[DayW-1:0];
    b.hour   = h[HourW-1:0];
    b.minute = mi[MinW-1:0];
    b.sec    = s[SecW-1:0];
    b.ofs    = ofs[OffW-1:0];
    return b;
  endfunction

  function automatic dt_beat_t rand_beat(input bit noisy);
    int unsigned y, mo, d, ofs;
    if (noisy) begin
      return mk_beat($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    y  = $urandom_range(9999, 1);
    mo = $urandom_range(12, 1);
    d  = $urandom_range(days_in(y, mo), 1);
    if ($urandom_range(9) == 0) begin
      mo = 1;
      d  = 1;
    end
    case ($urandom_range(4))
      0:       ofs = $urandom_range(DaySecs - 1);
      1:       ofs = $urandom_range(800) * DaySecs + $urandom_range(DaySecs - 1);
      2:       ofs = $urandom_range(24855) * DaySecs;
      default: ofs = $urandom_range(32'h7FFF_FFFF);
    endcase
    return mk_beat(y, mo, d, $urandom_range(23), $urandom_range(59), $urandom_range(59), ofs);
  endfunction

  task automatic report_error(input string msg);
    if (errors < PrintCap) $display("ERROR: %s", msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_error($sformatf("result %0d: %s is %0d, expected %0d",
                             results_seen, name, got, want));
    end
  endtask

  assign calm_in  = (beats_sent >= CalmFrom) && (beats_sent < CalmTo);
  assign calm_out = (results_seen >= CalmFrom) && (results_seen < CalmTo);

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        due_moments.push_back(advance_moment(cur_beat));
        beats_sent <= beats_sent + 1;
      end
      if (start_beats.size() != 0 && (calm_in || $urandom_range(99) >= 27)) begin
        cur_beat = start_beats.pop_front();
        s_axis_tdata  <= {1'b0, cur_beat};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && results_seen == HoldAt) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_moment = dt_moment_t'(m_axis_tdata);
        results_seen <= results_seen + 1;
        if (due_moments.size() == 0) begin
          report_error($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want_moment = due_moments.pop_front();
          check_field("year",   got_moment.year,   want_moment.year);
          check_field("month",  got_moment.month,  want_moment.month);
          check_field("day",    got_moment.day,    want_moment.day);
          check_field("hour",   got_moment.hour,   want_moment.hour);
          check_field("minute", got_moment.minute, want_moment.minute);
          check_field("second", got_moment.sec,    want_moment.sec);
        end
      end
      if (hold_left != 0) m_axis_tready <= 1'b0;
      else m_axis_tready <= calm_out || ($urandom_range(99) >= 27);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("ERROR: no beat moved for %0d cycles", StallLimit);
        $display("Simulation FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    bit noisy;
    // all zeros and all ones
    start_beats.push_back(mk_beat(0, 0, 0, 0, 0, 0, 0));
    start_beats.push_back(mk_beat(16383, 15, 31, 31, 63, 63, 32'h7FFF_FFFF));
    // range ends
    start_beats.push_back(mk_beat(1, 1, 1, 0, 0, 0, 0));
    start_beats.push_back(mk_beat(1, 1, 1, 0, 0, 0, DaySecs - 1));
    start_beats.push_back(mk_beat(9999, 12, 31, 23, 59, 59, 32'h7FFF_FFFF));
    start_beats.push_back(mk_beat(9999, 12, 31, 23, 59, 59, 1));
    start_beats.push_back(mk_beat(2023, 12, 31, 23, 59, 59, DaySecs));
    // leap rule
    start_beats.push_back(mk_beat(2000, 2, 28, 23, 59, 59, 1));
    start_beats.push_back(mk_beat(1900, 2, 28, 12, 0, 0, DaySecs));
    start_beats.push_back(mk_beat(400, 2, 28, 0, 0, 0, DaySecs));
    start_beats.push_back(mk_beat(2024, 2, 29, 0, 0, 0, DaySecs));
    start_beats.push_back(mk_beat(2100, 3, 1, 0, 0, 0, DaySecs - 1));
    start_beats.push_back(mk_beat(2000, 1, 1, 0, 0, 0, 366 * DaySecs));
    start_beats.push_back(mk_beat(2023, 1, 1, 0, 0, 0, 365 * DaySecs - 1));
    // month outside the calendar
    start_beats.push_back(mk_beat(2023, 0, 5, 10, 0, 0, 3 * DaySecs));
    start_beats.push_back(mk_beat(2023, 13, 5, 10, 0, 0, DaySecs));
    start_beats.push_back(mk_beat(2023, 15, 20, 0, 0, 0, 40 * DaySecs));
    // day zero or past month end
    start_beats.push_back(mk_beat(2023, 4, 0, 0, 0, 0, DaySecs));
    start_beats.push_back(mk_beat(2023, 2, 31, 0, 0, 0, 0));
    start_beats.push_back(mk_beat(2023, 2, 31, 0, 0, 0, 2 * DaySecs));
    // time of day out of range
    start_beats.push_back(mk_beat(2023, 6, 15, 31, 63, 63, 0));
    start_beats.push_back(mk_beat(2023, 6, 15, 31, 63, 63, 2 * DaySecs + 5));
    // year zero and year wrap
    start_beats.push_back(mk_beat(0, 6, 1, 0, 0, 0, 400 * DaySecs));
    start_beats.push_back(mk_beat(16383, 12, 31, 0, 0, 0, 400 * DaySecs));
    directed_cnt = start_beats.size();

    for (int i = 0; i < RandBeats; i++) begin
      noisy = ($urandom_range(99) < 15);
      if (noisy) noisy_cnt++;
      start_beats.push_back(rand_beat(noisy));
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (start_beats.size() != 0 || s_axis_tvalid || due_moments.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d beats: %0d directed corner cases, %0d random (%0d with raw fields)",
             beats_sent, directed_cnt, beats_sent - directed_cnt, noisy_cnt);
    $display("checked %0d results with %0d field mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
